### sv/vrd_pkg.sv
package vrd_pkg;

  localparam int FrameBitsDef      = 31;
  localparam int MaxStringBytesDef = 1048576;
  localparam int MaxFileBytesDef   = 33554432;

  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_DEATH = 3'd1,
    KIND_INPUT = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ERR_TRUNC     = 4'd0,
    ERR_VARINT    = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_STRLEN    = 4'd3,
    ERR_BOOL      = 4'd4,
    ERR_LEVEL     = 4'd5,
    ERR_DEATH_CNT = 4'd6,
    ERR_FRAME     = 4'd7,
    ERR_DEATH_OVF = 4'd8,
    ERR_INPUT_CNT = 4'd9,
    ERR_INPUT_OVF = 4'd10,
    ERR_TRAILING  = 4'd11,
    ERR_MAGIC     = 4'd12,
    ERR_TOO_LARGE = 4'd13
  } err_e;

  localparam logic [2:0] HF_DURATION = 3'd0;
  localparam logic [2:0] HF_RATE     = 3'd1;
  localparam logic [2:0] HF_SEED     = 3'd2;
  localparam logic [2:0] HF_LOW      = 3'd3;
  localparam logic [2:0] HF_PLAT     = 3'd4;
  localparam logic [2:0] HF_LEVEL    = 3'd5;
  localparam logic [2:0] HF_EXT      = 3'd6;

  localparam logic [1:0] CFG_TICK_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_RECORD_LIMIT = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              record_kind;
    logic [2:0]              header_field;
    logic [63:0]             header_value;
    logic [FrameBitsDef-1:0] frame;
    logic [1:0]              button;
    logic                    second_player;
    logic                    pressed;
    logic [3:0]              error_code;
    logic                    run_last;
  } out_item_t;

  // front to back: one byte plus the completed varint, if any
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        final_byte;
    logic        vdone;
    logic        vovf;
    logic [63:0] value;
  } tok_t;

endpackage

### sv/vrd_front.sv
module vrd_front import vrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     varint_mode_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output tok_t     q_data_o
);
  // varint assembly; varint_mode_i comes from the back phase after the queue drains
  logic [63:0] acc_q, acc_d;
  logic [3:0]  n_q, n_d;
  logic        fire;
  logic [63:0] shifted;

  assign in_stall_o = q_full_i;
  assign fire       = in_valid_i && !q_full_i;
  assign q_push_o   = fire;
  assign shifted    = 64'({57'd0, in_data_i.data_byte[6:0]}) << (7 * n_q);

  always_comb begin
    acc_d = acc_q;
    n_d   = n_q;
    q_data_o.data_byte  = in_data_i.data_byte;
    q_data_o.final_byte = in_data_i.final_byte;
    q_data_o.vdone = 1'b0;
    q_data_o.vovf  = 1'b0;
    q_data_o.value = acc_q | shifted;
    if (fire && varint_mode_i) begin
      if (n_q >= 4'd9 && (in_data_i.data_byte[7:1] != 7'd0)) begin
        q_data_o.vovf = 1'b1;
      end else if (!in_data_i.data_byte[7] || n_q >= 4'd9) begin
        q_data_o.vdone = 1'b1;
        acc_d = '0;
        n_d   = '0;
      end else begin
        acc_d = acc_q | shifted;
        n_d   = n_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      n_q   <= '0;
    end else begin
      acc_q <= acc_d;
      n_q   <= n_d;
    end
  end
endmodule

### sv/vrd_back.sv
module vrd_back import vrd_pkg::*; #(
  parameter int MAX_STRING_BYTES = MaxStringBytesDef,
  parameter int MAX_FILE_BYTES   = MaxFileBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_valid_i,
  input  tok_t        tok_i,
  output logic        tok_pop_o,
  output logic        varint_mode_o,
  input  logic [30:0] tick_limit_i,
  input  logic [31:0] record_limit_i,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i
);
  localparam int TB = $clog2(MAX_FILE_BYTES + 1);

  typedef enum logic [4:0] {
    PH_MAGIC = 5'd0, PH_VERSION = 5'd1, PH_TAG_LEN = 5'd2, PH_TAG_BODY = 5'd3,
    PH_AUTHOR_LEN = 5'd4, PH_AUTHOR_BODY = 5'd5, PH_DESC_LEN = 5'd6,
    PH_DESC_BODY = 5'd7, PH_DURATION = 5'd8, PH_SKIP_A = 5'd9, PH_RATE = 5'd10,
    PH_SEED = 5'd11, PH_SKIP_B = 5'd12, PH_LOW = 5'd13, PH_PLAT = 5'd14,
    PH_BOT_LEN = 5'd15, PH_BOT_BODY = 5'd16, PH_SKIP_C = 5'd17, PH_LEVEL = 5'd18,
    PH_NAME_LEN = 5'd19, PH_NAME_BODY = 5'd20, PH_EXT_LEN = 5'd21,
    PH_EXT_BODY = 5'd22, PH_DEATH_COUNT = 5'd23, PH_DEATH = 5'd24,
    PH_INPUT_COUNT = 5'd25, PH_INPUT_P1 = 5'd26, PH_INPUT = 5'd27,
    PH_BLOCK_LEN = 5'd28, PH_BLOCK_BODY = 5'd29, PH_END = 5'd30, PH_DONE = 5'd31
  } phase_e;

  // phases in which a byte is part of a varint
  function automatic logic varint_ph(phase_e p);
    logic r;
    unique case (p) inside
      PH_MAGIC, PH_DURATION, PH_RATE, PH_END, PH_DONE, PH_TAG_BODY, PH_AUTHOR_BODY,
      PH_DESC_BODY, PH_BOT_BODY, PH_NAME_BODY, PH_EXT_BODY, PH_BLOCK_BODY: r = 1'b0;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  phase_e      ph_q, ph_d;
  logic [63:0] fix_q, fix_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [63:0] skip_q, skip_d;
  logic        tag_q, tag_d, plat_q, plat_d;
  logic [31:0] left_q, left_d, p2_q, p2_d, idx_q, idx_d;
  logic [30:0] run_q, run_d;
  logic [TB-1:0] tot_q, tot_d;
  // two-entry output buffer so that both results of one byte fit
  out_item_t   ob_q [2];
  logic [1:0]  ocnt_q, ocnt_d, keep;
  out_item_t   ob0_d, ob1_d;

  out_item_t rec, tail;
  logic have, err, fin, body_ph, can_take;
  logic [3:0] ecode;
  logic [63:0] v, delta, fixn, skipm;
  logic [31:0] run_base, left_m;
  logic [63:0] sum;
  logic [63:0] tl;
  logic [7:0]  c;
  logic [1:0]  nres;

  // the front sees the phase that follows the byte taken this cycle
  assign varint_mode_o = tok_pop_o ? varint_ph(ph_d) : varint_ph(ph_q);
  assign body_ph = (ph_q == PH_TAG_BODY || ph_q == PH_AUTHOR_BODY ||
                    ph_q == PH_DESC_BODY || ph_q == PH_BOT_BODY ||
                    ph_q == PH_NAME_BODY || ph_q == PH_EXT_BODY || ph_q == PH_BLOCK_BODY);
  // at most two results per byte; take a byte when both slots could be freed
  assign can_take  = (ocnt_q == 2'd0) || (ocnt_q == 2'd1 && !out_stall_i);
  assign tok_pop_o = tok_valid_i && can_take;
  assign c   = tok_i.data_byte;
  assign fin = tok_i.final_byte;
  assign v   = tok_i.value;
  assign tl  = 64'(tick_limit_i);
  assign fixn  = {fix_q[55:0], c};
  assign skipm = skip_q - 64'd1;
  assign left_m = left_q - 32'd1;

  always_comb begin
    ph_d = ph_q; fix_d = fix_q; fcnt_d = fcnt_q; skip_d = skip_q;
    tag_d = tag_q; plat_d = plat_q; left_d = left_q; p2_d = p2_q; idx_d = idx_q;
    run_d = run_q; tot_d = tot_q;
    rec = '0; tail = '0; have = 1'b0; err = 1'b0; ecode = ERR_TRUNC;
    delta = '0; run_base = 32'(run_q); sum = '0;
    if (ph_q != PH_DONE) begin
      if (tot_q >= TB'(MAX_FILE_BYTES)) begin
        err = 1'b1; ecode = ERR_TOO_LARGE;
      end else begin
        tot_d = tot_q + TB'(1);
        if (ph_q == PH_MAGIC) begin
          if ((tot_q == '0 && c != "G") || (tot_q == TB'(1) && c != "D") ||
              (tot_q == TB'(2) && c != "R")) begin
            err = 1'b1; ecode = ERR_MAGIC;
          end else if (tot_q == TB'(2)) begin
            ph_d = PH_VERSION;
          end
        end else if (body_ph) begin
          skip_d = skipm;
          if (skipm == '0) begin
            if (ph_q == PH_BLOCK_BODY) ph_d = (left_q == '0) ? PH_END : PH_INPUT;
            else ph_d = phase_e'(ph_q + 5'd1);
          end
        end else if (ph_q == PH_DURATION || ph_q == PH_RATE) begin
          fix_d = fixn; fcnt_d = fcnt_q + 4'd1;
          if (fcnt_d == ((ph_q == PH_DURATION) ? 4'd4 : 4'd8)) begin
            have = 1'b1; rec.record_kind = KIND_HDR;
            rec.header_field = (ph_q == PH_DURATION) ? HF_DURATION : HF_RATE;
            rec.header_value = fixn;
            ph_d = (ph_q == PH_DURATION) ? PH_SKIP_A : PH_SEED;
            fix_d = '0; fcnt_d = '0;
          end
        end else if (ph_q == PH_END) begin
          err = 1'b1; ecode = ERR_TRAILING;
        end else if (tok_i.vovf) begin
          err = 1'b1; ecode = ERR_VARINT;
        end else if (tok_i.vdone) begin
          unique case (ph_q)
            PH_VERSION: if (v != 64'd2) begin err = 1'b1; ecode = ERR_VERSION; end
                        else ph_d = PH_TAG_LEN;
            PH_TAG_LEN, PH_AUTHOR_LEN, PH_DESC_LEN, PH_BOT_LEN, PH_NAME_LEN: begin
              if (ph_q == PH_TAG_LEN) tag_d = (v != '0);
              if (v > 64'(MAX_STRING_BYTES)) begin err = 1'b1; ecode = ERR_STRLEN; end
              else if (v == '0) ph_d = phase_e'(ph_q + 5'd2);
              else begin skip_d = v; ph_d = phase_e'(ph_q + 5'd1); end
            end
            PH_SKIP_A: ph_d = PH_RATE;
            PH_SEED: begin
              have = 1'b1; rec.header_field = HF_SEED; rec.header_value = v;
              ph_d = PH_SKIP_B;
            end
            PH_SKIP_B: ph_d = PH_LOW;
            PH_LOW, PH_PLAT: begin
              if (v > 64'd1) begin err = 1'b1; ecode = ERR_BOOL; end
              else begin
                have = 1'b1; rec.header_value = v;
                rec.header_field = (ph_q == PH_LOW) ? HF_LOW : HF_PLAT;
                if (ph_q == PH_PLAT) plat_d = v[0];
                ph_d = phase_e'(ph_q + 5'd1);
              end
            end
            PH_SKIP_C: ph_d = PH_LEVEL;
            PH_LEVEL: begin
              if (v[63:32] != '0) begin err = 1'b1; ecode = ERR_LEVEL; end
              else begin
                have = 1'b1; rec.header_field = HF_LEVEL; rec.header_value = v;
                ph_d = PH_NAME_LEN;
              end
            end
            PH_EXT_LEN: begin
              have = 1'b1; rec.header_field = HF_EXT;
              rec.header_value = {63'd0, (v != '0) || tag_q};
              if (v == '0) ph_d = PH_DEATH_COUNT;
              else begin skip_d = v; ph_d = PH_EXT_BODY; end
            end
            PH_DEATH_COUNT: begin
              if (v > 64'(record_limit_i)) begin err = 1'b1; ecode = ERR_DEATH_CNT; end
              else begin
                left_d = v[31:0]; run_d = '0;
                ph_d = (v == '0) ? PH_INPUT_COUNT : PH_DEATH;
              end
            end
            PH_INPUT_COUNT: begin
              if (v > 64'(record_limit_i)) begin err = 1'b1; ecode = ERR_INPUT_CNT; end
              else begin left_d = v[31:0]; ph_d = PH_INPUT_P1; end
            end
            PH_INPUT_P1: begin
              if (v > 64'(left_q)) begin err = 1'b1; ecode = ERR_INPUT_CNT; end
              else begin
                p2_d = v[31:0]; idx_d = '0; run_d = '0;
                ph_d = (left_q == '0) ? PH_END : PH_INPUT;
              end
            end
            PH_DEATH, PH_INPUT: begin
              if (ph_q == PH_INPUT) begin
                if (idx_q == p2_q) run_base = '0;
                delta = plat_q ? (v >> 3) : (v >> 1);
              end else delta = v;
              sum = 64'(run_base) + delta;
              if (delta > tl) begin err = 1'b1; ecode = ERR_FRAME; end
              else if (64'(run_base) > tl || sum > tl) begin
                err = 1'b1; ecode = (ph_q == PH_DEATH) ? ERR_DEATH_OVF : ERR_INPUT_OVF;
              end else begin
                have = 1'b1; run_d = sum[30:0]; rec.frame = sum[30:0];
                left_d = left_m;
                if (ph_q == PH_DEATH) begin
                  rec.record_kind = KIND_DEATH;
                  if (left_m == '0) ph_d = PH_INPUT_COUNT;
                end else begin
                  rec.record_kind = KIND_INPUT;
                  rec.button = plat_q ? v[2:1] : 2'd1;
                  rec.second_player = (idx_q >= p2_q);
                  rec.pressed = v[0];
                  idx_d = idx_q + 32'd1;
                  if (tag_q) ph_d = PH_BLOCK_LEN;
                  else ph_d = (left_m == '0) ? PH_END : PH_INPUT;
                end
              end
            end
            PH_BLOCK_LEN: begin
              if (v == '0) ph_d = (left_q == '0) ? PH_END : PH_INPUT;
              else begin skip_d = v; ph_d = PH_BLOCK_BODY; end
            end
            default: ;
          endcase
        end
      end
      if (err) begin
        have = 1'b0;
        tail.record_kind = KIND_ERR; tail.error_code = ecode; tail.run_last = 1'b1;
        ph_d = PH_DONE;
      end else if (fin) begin
        tail.run_last = 1'b1;
        if (ph_d == PH_END) tail.record_kind = KIND_END;
        else begin
          tail.record_kind = KIND_ERR;
          tail.error_code = (ph_d == PH_MAGIC) ? ERR_MAGIC : ERR_TRUNC;
        end
        ph_d = PH_DONE;
      end
      rec.run_last = !fin;
    end
  end

  assign nres = 2'(have) + 2'(err || (fin && ph_q != PH_DONE));
  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_data_o  = ob_q[0];

  // result buffer: shift out on a transfer, then append this byte's results
  always_comb begin
    ob0_d = ob_q[0];
    ob1_d = ob_q[1];
    keep  = ocnt_q;
    if (out_valid_o && !out_stall_i) begin
      ob0_d = ob_q[1];
      keep  = ocnt_q - 2'd1;
    end
    ocnt_d = keep;
    if (tok_pop_o) begin
      if (keep == 2'd0) begin
        ob0_d = have ? rec : tail;
        ob1_d = tail;
      end else begin
        ob1_d = have ? rec : tail;
      end
      ocnt_d = keep + nres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC; fix_q <= '0; fcnt_q <= '0; skip_q <= '0;
      tag_q <= 1'b0; plat_q <= 1'b0; left_q <= '0; p2_q <= '0; idx_q <= '0;
      run_q <= '0; tot_q <= '0; ocnt_q <= '0;
      ob_q[0] <= '0; ob_q[1] <= '0;
    end else begin
      if (tok_pop_o) begin
        ph_q <= ph_d; fix_q <= fix_d; fcnt_q <= fcnt_d; skip_q <= skip_d;
        tag_q <= tag_d; plat_q <= plat_d; left_q <= left_d; p2_q <= p2_d;
        idx_q <= idx_d; run_q <= run_d; tot_q <= tot_d;
      end
      ob_q[0] <= ob0_d;
      ob_q[1] <= ob1_d;
      ocnt_q  <= ocnt_d;
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) ocnt_q <= 2'd2)
    else $error("output buffer overfilled");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_pop_o && ph_q == PH_DONE) |-> nres == 2'd0)
    else $error("result after end");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o |-> (ocnt_q != 2'd2))
    else $error("byte taken with full buffer");
endmodule

### sv/varint_replay_record_decoder_core.sv
// replay byte-stream decoder: one byte per transfer on the input channel, records
// (header values, death frames, input events, end or error) on the output channel.
// sustained rate is one byte per cycle without output stall; a varint byte is
// assembled in the front, the phase sequencer in the back acts on it, with a
// one-entry queue between them and a two-entry result buffer at the output, both
// registered. the input stalls only while the queue holds a byte that the back cannot
// take, which happens when a result waits under output stall or the buffer is full.
// configuration writes are always ready
module varint_replay_record_decoder_core import vrd_pkg::*; #(
  parameter int MAX_STRING_BYTES = MaxStringBytesDef,
  parameter int MAX_FILE_BYTES   = MaxFileBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        cfg_ready_o
);
  logic [30:0] tick_q;
  logic [31:0] rec_lim_q;
  logic        qv_q, push, pop, vmode, q_busy;
  tok_t        qd_q, tok;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 31'h7fffffff; rec_lim_q <= 32'hffffffff;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TICK_LIMIT) tick_q <= cfg_data_i[30:0];
      else if (cfg_index_i == CFG_RECORD_LIMIT) rec_lim_q <= cfg_data_i;
    end
  end

  // a byte enters when the queue is empty or is being popped; vmode of the back
  // then already reflects the phase after the popped byte
  assign q_busy = qv_q && !pop;

  vrd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .varint_mode_i(vmode), .q_full_i(q_busy), .q_push_o(push), .q_data_o(tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qv_q <= 1'b0;
    else qv_q <= push || (qv_q && !pop);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qd_q <= '0;
    else if (push) qd_q <= tok;
  end

  vrd_back #(.MAX_STRING_BYTES(MAX_STRING_BYTES),
             .MAX_FILE_BYTES(MAX_FILE_BYTES)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(qv_q), .tok_i(qd_q), .tok_pop_o(pop),
    .varint_mode_o(vmode), .tick_limit_i(tick_q), .record_limit_i(rec_lim_q),
    .out_valid_o, .out_data_o, .out_stall_i
  );

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == CFG_TICK_LIMIT) |=> tick_q == $past(cfg_data_i[30:0]))
    else $error("tick limit write lost");
  a_q: assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> (!qv_q || pop))
    else $error("queue overwrite");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> qv_q)
    else $error("pop of empty queue");
endmodule
